FILE: hdl/zwm_pkg.sv
// Shared types, constants and tables for the Zernike window moment block.
package zwm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int MAX_ORDER  = 12;
    localparam int FRAC       = 24;

    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int SIDE_W = POS_W + 1;
    localparam int AB_W   = POS_W + 1;
    localparam int D2_W   = 2 * POS_W + 1;

    localparam int DIV_NUM_W = 52;
    localparam int DIV_DEN_W = 29;
    localparam int DIV_CNT_W = 6;

    localparam int SQ_IN_W  = 42;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_CNT_W = $clog2(SQ_OUT_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [23:0] INV_SQRT2 = 24'd11863283;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_ORDER       = 2'd0;
    localparam reg_index_t REG_REPETITION  = 2'd1;
    localparam reg_index_t REG_WINDOW_SIZE = 2'd2;

    typedef struct packed {
        logic [3:0]        order;
        logic signed [4:0] repetition;
        logic [SIDE_W-1:0] side;
    } zwm_cfg_t;

    typedef struct packed {
        logic [7:0]             pixel;
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
        logic [D2_W-1:0]        d2;
        logic                   in_disk;
        logic                   last;
    } zwm_item_t;

    typedef enum logic [4:0] {
        BK_IDLE,
        BK_R2_GO,
        BK_R2_WAIT,
        BK_U_GO,
        BK_U_WAIT,
        BK_V_GO,
        BK_V_WAIT,
        BK_H_INIT,
        BK_H_MUL,
        BK_H_ADD,
        BK_W_INIT,
        BK_W1,
        BK_W2,
        BK_W3,
        BK_W4,
        BK_W5,
        BK_T1,
        BK_T2,
        BK_T3,
        BK_T4,
        BK_T5,
        BK_NEXT,
        BK_FIN,
        BK_RE_WAIT,
        BK_IM_GO,
        BK_IM_WAIT,
        BK_SQ1,
        BK_SQ2,
        BK_SQ3,
        BK_SQRT_WAIT,
        BK_OUT
    } back_state_t;

    typedef logic [MAX_ORDER:0][MAX_ORDER:0][9:0] binom_tab_t;

    // Pascal triangle, built by additions at elaboration
    function automatic binom_tab_t build_binom();
        binom_tab_t t;
        t = '0;
        for (int i = 0; i <= MAX_ORDER; i++) begin
            t[i][0] = 10'd1;
            for (int j = 1; j <= i; j++) begin
                t[i][j] = t[i-1][j-1] + ((j < i) ? t[i-1][j] : 10'd0);
            end
        end
        return t;
    endfunction

    localparam binom_tab_t BINOM = build_binom();

endpackage

FILE: hdl/zwm_front.sv
// Front end: window position tracking and per-pixel geometry.
module zwm_front import zwm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  zwm_cfg_t  cfg,
    input  logic      clear,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] pixel,
    input  logic      full,
    output logic      push,
    output zwm_item_t item
);

    logic [POS_W-1:0]     col_reg;
    logic [POS_W-1:0]     col_next;
    logic [POS_W-1:0]     row_reg;
    logic [POS_W-1:0]     row_next;
    logic [POS_W-1:0]     nm1;
    logic [2*POS_W-1:0]   nm1_sq;
    logic signed [AB_W:0] a_wide;
    logic signed [AB_W:0] b_wide;
    logic signed [13:0]   a_sq;
    logic signed [13:0]   b_sq;
    logic [D2_W-1:0]      d2;
    logic [D2_W-1:0]      lim;

    assign nm1    = POS_W'(cfg.side - SIDE_W'(1));
    assign nm1_sq = nm1 * nm1;
    assign lim    = {nm1_sq, 1'b0};

    assign a_wide = $signed({1'b0, col_reg, 1'b0}) - $signed({1'b0, cfg.side})
                    + (AB_W+1)'(1);
    assign b_wide = $signed({2'b0, nm1}) - $signed({1'b0, row_reg, 1'b0});

    assign a_sq = item.a * item.a;
    assign b_sq = item.b * item.b;
    assign d2   = D2_W'(a_sq + b_sq);

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        item.pixel   = pixel;
        item.a       = a_wide[AB_W-1:0];
        item.b       = b_wide[AB_W-1:0];
        item.d2      = d2;
        item.in_disk = (d2 <= lim);
        item.last    = (col_reg == nm1) && (row_reg == nm1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (clear) begin
            col_next = '0;
            row_next = '0;
        end else if (push) begin
            if (col_reg == nm1) begin
                col_next = '0;
                row_next = (row_reg == nm1) ? '0 : row_reg + POS_W'(1);
            end else begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hdl/zwm_queue.sv
// Short word queue between the front end and the back end.
module zwm_queue import zwm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  zwm_item_t push_item,
    output logic      full,
    input  logic      pop,
    output zwm_item_t pop_item,
    output logic      empty
);

    zwm_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/zwm_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module zwm_divider import zwm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  logic [DIV_CNT_W-1:0] iters,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quo     = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            // align the top significant bit with the MSB
            num_reg <= num << (DIV_CNT_W'(DIV_NUM_W) - iters);
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

endmodule

FILE: hdl/zwm_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module zwm_isqrt import zwm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  x,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_IN_W-1:0]  x_reg;
    logic [SQ_IN_W-1:0]  r_reg;
    logic [SQ_IN_W-1:0]  bit_reg;
    logic [SQ_IN_W-1:0]  trial;
    logic                ge;

    assign trial = r_reg + bit_reg;
    assign ge    = (x_reg >= trial);
    assign done  = done_reg;
    assign root  = r_reg[SQ_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(SQ_OUT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SQ_CNT_W'(1);
                if (cnt_reg == SQ_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            x_reg   <= x;
            r_reg   <= '0;
            bit_reg <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end else if (busy_reg) begin
            if (ge) begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

FILE: hdl/zwm_back.sv
// Back end: radial polynomial, angle power, accumulation and final scaling.
module zwm_back import zwm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  zwm_cfg_t           cfg,
    input  logic               clear,
    input  logic               empty,
    input  zwm_item_t          head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] moment_real,
    output logic signed [20:0] moment_imag,
    output logic [19:0]        magnitude,
    output logic               config_ok
);

    localparam logic [19:0] OUT_MAX = 20'hFFFFF;

    back_state_t state_reg;
    back_state_t state_next;

    zwm_item_t          cur_reg;
    logic [12:0]        count_reg;
    logic signed [47:0] real_sum_reg;
    logic signed [47:0] imag_sum_reg;
    logic [24:0]        r2_reg;
    logic signed [25:0] u_reg;
    logic signed [25:0] v_reg;
    logic signed [39:0] acc_reg;
    logic [2:0]         s_reg;
    logic [3:0]         t_reg;
    logic signed [25:0] wr_reg;
    logic signed [25:0] wi_reg;
    logic signed [25:0] nr_reg;
    logic signed [65:0] tmp_reg;
    logic signed [39:0] term_re_reg;
    logic signed [39:0] term_im_reg;
    logic signed [65:0] prod_reg;
    logic signed [20:0] re_reg;
    logic signed [20:0] im_reg;
    logic [19:0]        mag_reg;
    logic [SQ_IN_W-1:0] sq_reg;
    logic               out_valid_reg;
    logic signed [20:0] real_out_reg;
    logic signed [20:0] imag_out_reg;
    logic [19:0]        mag_out_reg;
    logic               ok_out_reg;

    logic [4:0]         mm;
    logic [4:0]         n5;
    logic               cfg_valid;
    logic [3:0]         k;
    logic [5:0]         nm1;
    logic [11:0]        nm1_sq;
    logic [5:0]         abs_a;
    logic [5:0]         abs_b;
    logic [13:0]        coef;
    logic signed [39:0] coef_term;
    logic signed [39:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [53:0] p_re;
    logic signed [53:0] p_im;
    logic [52:0]        mag_p_re;
    logic [52:0]        mag_p_im;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 sq_start;
    logic                 sq_done;
    logic [SQ_OUT_W-1:0]  sq_root;
    logic                 out_load;

    function automatic logic signed [42:0] round_q24(input logic signed [66:0] x);
        logic [66:0] mag;
        logic [42:0] q;
        mag = x[66] ? 67'(-x) : 67'(x);
        q   = 43'((mag + 67'd8388608) >> FRAC);
        return x[66] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [20:0] sat_out(input logic [DIV_NUM_W-1:0] q,
                                                   input logic neg);
        logic signed [20:0] res;
        if (neg) begin
            res = (q >= DIV_NUM_W'(1048576)) ? 21'sh100000
                                             : 21'sd0 - $signed({1'b0, q[19:0]});
        end else begin
            res = (q > DIV_NUM_W'(OUT_MAX)) ? $signed({1'b0, OUT_MAX})
                                            : $signed({1'b0, q[19:0]});
        end
        return res;
    endfunction

    // multinomial (n-s)! / (s! (hp-s)! (k-s)!) as a product of two binomials
    function automatic logic [13:0] coef_of(input logic [3:0] n, input logic [3:0] kk,
                                            input logic [2:0] s);
        logic [3:0] s4;
        logic [3:0] row1;
        logic [3:0] row2;
        logic [3:0] col2;
        s4   = {1'b0, s};
        row1 = n - s4;
        row2 = n - (s4 << 1);
        col2 = kk - s4;
        return 14'(BINOM[row1][s4]) * 14'(BINOM[row2][col2]);
    endfunction

    assign mm        = cfg.repetition[4] ? 5'(-cfg.repetition) : cfg.repetition;
    assign n5        = {1'b0, cfg.order};
    assign cfg_valid = (cfg.order <= 4'(MAX_ORDER)) && (mm <= n5)
                       && (cfg.order[0] == mm[0]);
    assign k         = 4'((n5 - mm) >> 1);
    assign nm1       = 6'(cfg.side - SIDE_W'(1));
    assign nm1_sq    = nm1 * nm1;
    assign abs_a     = cur_reg.a[AB_W-1] ? 6'(-cur_reg.a) : 6'(cur_reg.a);
    assign abs_b     = cur_reg.b[AB_W-1] ? 6'(-cur_reg.b) : 6'(cur_reg.b);
    assign coef      = coef_of(cfg.order, k, s_reg);
    assign coef_term = s_reg[0] ? -$signed({2'b0, coef, 24'b0}) : $signed({2'b0, coef, 24'b0});

    assign p_re     = $signed({1'b0, 5'(n5 + 5'd1)}) * real_sum_reg;
    assign p_im     = $signed({1'b0, 5'(n5 + 5'd1)}) * imag_sum_reg;
    assign mag_p_re = p_re[53] ? 53'(-p_re) : 53'(p_re);
    assign mag_p_im = p_im[53] ? 53'(-p_im) : 53'(p_im);

    assign out_valid   = out_valid_reg;
    assign moment_real = real_out_reg;
    assign moment_imag = imag_out_reg;
    assign magnitude   = mag_out_reg;
    assign config_ok   = ok_out_reg;

    zwm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .iters (div_iters),
        .done  (div_done),
        .quo   (div_quo)
    );

    zwm_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (sq_reg + prod_reg[SQ_IN_W-1:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = $signed({1'b0, r2_reg});
        case (state_reg)
            BK_W1:  begin mul_a = 40'(wr_reg); mul_b = u_reg; end
            BK_W2:  begin mul_a = 40'(wi_reg); mul_b = v_reg; end
            BK_W3:  begin mul_a = 40'(wr_reg); mul_b = v_reg; end
            BK_W4:  begin mul_a = 40'(wi_reg); mul_b = u_reg; end
            BK_T1:  begin mul_a = acc_reg;     mul_b = wr_reg; end
            BK_T2:  begin mul_a = acc_reg;     mul_b = wi_reg; end
            BK_T3:  begin mul_a = term_re_reg; mul_b = $signed({18'b0, cur_reg.pixel}); end
            BK_T4:  begin mul_a = term_im_reg; mul_b = $signed({18'b0, cur_reg.pixel}); end
            BK_SQ1: begin mul_a = 40'(re_reg);  mul_b = 26'(re_reg); end
            BK_SQ2: begin mul_a = 40'(im_reg);  mul_b = 26'(im_reg); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        div_iters  = '0;
        sq_start   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    state_next = (head.in_disk && cfg_valid) ? BK_R2_GO : BK_NEXT;
                end
            end
            BK_R2_GO: begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'({cur_reg.d2, 23'b0}) + DIV_NUM_W'(nm1_sq[11:1]);
                div_den    = DIV_DEN_W'(nm1_sq);
                div_iters  = DIV_CNT_W'(36);
                state_next = BK_R2_WAIT;
            end
            BK_R2_WAIT: if (div_done) state_next = BK_U_GO;
            BK_U_GO: begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(30'(abs_a) * INV_SQRT2) + DIV_NUM_W'(nm1[5:1]);
                div_den    = DIV_DEN_W'(nm1);
                div_iters  = DIV_CNT_W'(30);
                state_next = BK_U_WAIT;
            end
            BK_U_WAIT: if (div_done) state_next = BK_V_GO;
            BK_V_GO: begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(30'(abs_b) * INV_SQRT2) + DIV_NUM_W'(nm1[5:1]);
                div_den    = DIV_DEN_W'(nm1);
                div_iters  = DIV_CNT_W'(30);
                state_next = BK_V_WAIT;
            end
            BK_V_WAIT: if (div_done) state_next = BK_H_INIT;
            BK_H_INIT: state_next = (k == 4'd0) ? BK_W_INIT : BK_H_MUL;
            BK_H_MUL:  state_next = BK_H_ADD;
            BK_H_ADD:  state_next = ({1'b0, s_reg} == k) ? BK_W_INIT : BK_H_MUL;
            BK_W_INIT: state_next = (mm == 5'd0) ? BK_T1 : BK_W1;
            BK_W1:     state_next = BK_W2;
            BK_W2:     state_next = BK_W3;
            BK_W3:     state_next = BK_W4;
            BK_W4:     state_next = BK_W5;
            BK_W5:     state_next = (5'(t_reg + 4'd1) == mm) ? BK_T1 : BK_W1;
            BK_T1:     state_next = BK_T2;
            BK_T2:     state_next = BK_T3;
            BK_T3:     state_next = BK_T4;
            BK_T4:     state_next = BK_T5;
            BK_T5:     state_next = BK_NEXT;
            BK_NEXT:   state_next = cur_reg.last ? BK_FIN : BK_IDLE;
            BK_FIN: begin
                if (cfg_valid && (count_reg != '0)) begin
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(mag_p_re) + DIV_NUM_W'({count_reg, 15'b0});
                    div_den    = {count_reg, 16'b0};
                    div_iters  = DIV_CNT_W'(DIV_NUM_W);
                    state_next = BK_RE_WAIT;
                end else begin
                    state_next = BK_OUT;
                end
            end
            BK_RE_WAIT: if (div_done) state_next = BK_IM_GO;
            BK_IM_GO: begin
                div_start  = 1'b1;
                div_num    = DIV_NUM_W'(mag_p_im) + DIV_NUM_W'({count_reg, 15'b0});
                div_den    = {count_reg, 16'b0};
                div_iters  = DIV_CNT_W'(DIV_NUM_W);
                state_next = BK_IM_WAIT;
            end
            BK_IM_WAIT: if (div_done) state_next = BK_SQ1;
            BK_SQ1: state_next = BK_SQ2;
            BK_SQ2: state_next = BK_SQ3;
            BK_SQ3: begin
                sq_start   = 1'b1;
                state_next = BK_SQRT_WAIT;
            end
            BK_SQRT_WAIT: if (sq_done) state_next = BK_OUT;
            BK_OUT: begin
                if (!out_valid_reg || !out_stall) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // window accumulators and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            real_sum_reg  <= '0;
            imag_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
            if (clear || out_load) begin
                count_reg    <= '0;
                real_sum_reg <= '0;
                imag_sum_reg <= '0;
            end else begin
                if (pop && head.in_disk) begin
                    count_reg <= count_reg + 13'd1;
                end
                if (state_reg == BK_T4) begin
                    real_sum_reg <= real_sum_reg + prod_reg[47:0];
                end
                if (state_reg == BK_T5) begin
                    imag_sum_reg <= imag_sum_reg - prod_reg[47:0];
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (pop) begin
            cur_reg <= head;
        end
        if (out_load) begin
            real_out_reg <= re_reg;
            imag_out_reg <= im_reg;
            mag_out_reg  <= mag_reg;
            ok_out_reg   <= cfg_valid;
        end
        case (state_reg)
            BK_R2_GO: s_reg <= 3'd0;
            BK_R2_WAIT: if (div_done) r2_reg <= div_quo[24:0];
            BK_U_WAIT: begin
                if (div_done) begin
                    u_reg <= cur_reg.a[AB_W-1] ? -$signed(div_quo[25:0]) : $signed(div_quo[25:0]);
                end
            end
            BK_V_WAIT: begin
                if (div_done) begin
                    v_reg <= cur_reg.b[AB_W-1] ? -$signed(div_quo[25:0]) : $signed(div_quo[25:0]);
                end
            end
            BK_H_INIT: begin
                acc_reg <= coef_term;
                s_reg   <= 3'd1;
            end
            BK_H_ADD: begin
                acc_reg <= 40'(round_q24(67'(prod_reg))) + coef_term;
                s_reg   <= s_reg + 3'd1;
            end
            BK_W_INIT: begin
                wr_reg <= 26'sd16777216;
                wi_reg <= '0;
                t_reg  <= '0;
            end
            BK_W2: tmp_reg <= prod_reg;
            BK_W3: nr_reg  <= 26'(round_q24(67'(tmp_reg) - 67'(prod_reg)));
            BK_W4: tmp_reg <= prod_reg;
            BK_W5: begin
                wi_reg <= 26'(round_q24(67'(tmp_reg) + 67'(prod_reg)));
                wr_reg <= nr_reg;
                t_reg  <= t_reg + 4'd1;
            end
            BK_T2: term_re_reg <= 40'(round_q24(67'(prod_reg)));
            BK_T3: term_im_reg <= 40'(round_q24(67'(prod_reg)));
            BK_FIN: begin
                re_reg  <= '0;
                im_reg  <= '0;
                mag_reg <= '0;
            end
            BK_RE_WAIT: if (div_done) re_reg <= sat_out(div_quo, p_re[53]);
            BK_IM_WAIT: begin
                if (div_done) begin
                    // conjugate for negative repetition
                    im_reg <= sat_out(div_quo, p_im[53] ^ cfg.repetition[4]);
                end
            end
            BK_SQ2: sq_reg <= prod_reg[SQ_IN_W-1:0];
            BK_SQRT_WAIT: begin
                if (sq_done) begin
                    mag_reg <= (sq_root > SQ_OUT_W'(OUT_MAX)) ? OUT_MAX : sq_root[19:0];
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/zernike_window_moment.sv
// Zernike window moment: a pixel inside the disk with a valid order runs the shared
// serial divider (r^2, u, v), then a multiply and add per radial step and a complex
// multiply per power of the angle term on the single shared multiplier. A pixel
// outside the disk or under an invalid order skips this; for a valid order the last
// pixel, with pixels in the disk, adds two 52-step divides and a 21-step sqrt.
// Reset sets order 0, repetition 0, window size 16 and clears position and sums.
module zernike_window_moment import zwm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] moment_real,
    output logic signed [20:0] moment_imag,
    output logic [19:0]        magnitude,
    output logic               config_ok
);

    logic [3:0]        order_reg;
    logic [4:0]        repetition_reg;
    logic [6:0]        window_size_reg;
    logic              cfg_clear;
    zwm_cfg_t          cfg;
    logic              push;
    logic              full;
    logic              pop;
    logic              empty;
    zwm_item_t         push_item;
    zwm_item_t         head;

    always_comb
    begin
        cfg_clear = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER, REG_REPETITION, REG_WINDOW_SIZE: cfg_clear = 1'b1;
                default: cfg_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            order_reg       <= '0;
            repetition_reg  <= '0;
            window_size_reg <= 7'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORDER:       order_reg       <= cfg_wdata[3:0];
                REG_REPETITION:  repetition_reg  <= cfg_wdata[4:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp the window side into the supported range
    always_comb
    begin
        cfg.order      = order_reg;
        cfg.repetition = $signed(repetition_reg);
        if (window_size_reg < 7'd2) begin
            cfg.side = SIDE_W'(2);
        end else if (window_size_reg > 7'(MAX_WINDOW)) begin
            cfg.side = SIDE_W'(MAX_WINDOW);
        end else begin
            cfg.side = SIDE_W'(window_size_reg);
        end
    end

    zwm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .clear    (cfg_clear),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel    (pixel),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    zwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (head),
        .empty     (empty)
    );

    zwm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .clear       (cfg_clear),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .moment_real (moment_real),
        .moment_imag (moment_imag),
        .magnitude   (magnitude),
        .config_ok   (config_ok)
    );

endmodule

FILE: tb/zernike_window_moment_tb.sv
// Self-checking testbench for the Zernike window moment block.
`timescale 1ns / 100ps

module zernike_window_moment_tb;
    import zwm_pkg::*;

    localparam int          SETTLE_CYCLES = 2000;
    localparam longint      CYCLE_LIMIT   = 3000000;
    localparam int          ITEM_TARGET   = 700;
    localparam reg_index_t  REG_SPARE     = 2'd3;

    typedef struct {
        logic signed [20:0] re;
        logic signed [20:0] im;
        logic [19:0]        mag;
        logic               ok;
    } moment_t;

    class moment_predictor;
        bit [3:0]          order;
        bit [4:0]          rep;
        bit [6:0]          side;
        int                row;
        int                col;
        bit [12:0]         count;
        longint            rsum;
        longint            isum;
        longint unsigned   fact[13];
        moment_t           pending[$];
        int                errors;

        function new();
            fact[0] = 1;
            for (int i = 1; i < 13; i++)
            begin
                fact[i] = fact[i-1] * i;
            end
            order  = 0;
            rep    = 0;
            side   = 16;
            errors = 0;
            clear_window();
        endfunction

        function void clear_window();
            row   = 0;
            col   = 0;
            count = 0;
            rsum  = 0;
            isum  = 0;
        endfunction

        function void write_reg(reg_index_t idx, bit [6:0] val);
            if (idx == REG_ORDER)
                order = val[3:0];
            else if (idx == REG_REPETITION)
                rep = val[4:0];
            else if (idx == REG_WINDOW_SIZE)
                side = val;
            else
                return;
            clear_window();
        endfunction

        function longint rnd_div(longint num, longint den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint wrap48(longint x);
            logic signed [47:0] t;
            t = x[47:0];
            return t;
        endfunction

        function longint sat(longint x);
            if (x > 1048575)
                return 1048575;
            if (x < -1048576)
                return -1048576;
            return x;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_pixel(bit [7:0] p);
            int      n;
            int      m;
            int      mm;
            int      k;
            int      hp;
            bit      ok;
            longint  nside;
            longint  a;
            longint  b;
            longint  d2;
            longint  nm1;
            longint  r2;
            longint  u;
            longint  v;
            longint  acc;
            longint  wr;
            longint  wi;
            longint  nr;
            longint  ni;
            longint  cs;
            longint  re;
            longint  im;
            longint  den;
            longint unsigned mag;
            moment_t res;
            n  = order;
            m  = $signed(rep);
            mm = (m < 0) ? -m : m;
            ok = (n <= MAX_ORDER) && (mm <= n) && (((n - mm) & 1) == 0);
            nside = side;
            if (nside < 2)
                nside = 2;
            if (nside > MAX_WINDOW)
                nside = MAX_WINDOW;
            a   = 2 * col - nside + 1;
            b   = nside - 1 - 2 * row;
            d2  = a * a + b * b;
            nm1 = nside - 1;
            if (d2 <= 2 * nm1 * nm1)
            begin
                count = count + 1;
                if (ok)
                begin
                    r2  = rnd_div(d2 * (64'sd1 << 23), nm1 * nm1);
                    u   = rnd_div(a * 11863283, nm1);
                    v   = rnd_div(b * 11863283, nm1);
                    k   = (n - mm) / 2;
                    hp  = (n + mm) / 2;
                    acc = 0;
                    for (int s = 0; s <= k; s++)
                    begin
                        cs = fact[n-s] / (fact[s] * fact[hp-s] * fact[k-s]);
                        if (s & 1)
                            cs = -cs;
                        if (s > 0)
                            acc = rnd_div(acc * r2, 64'sd1 << 24);
                        acc = acc + cs * (64'sd1 << 24);
                    end
                    wr = 64'sd1 << 24;
                    wi = 0;
                    for (int t = 0; t < mm; t++)
                    begin
                        nr = rnd_div(wr * u - wi * v, 64'sd1 << 24);
                        ni = rnd_div(wr * v + wi * u, 64'sd1 << 24);
                        wr = nr;
                        wi = ni;
                    end
                    rsum = wrap48(rsum + p * rnd_div(acc * wr, 64'sd1 << 24));
                    isum = wrap48(isum - p * rnd_div(acc * wi, 64'sd1 << 24));
                end
            end
            col++;
            if (col < nside)
                return;
            col = 0;
            row++;
            if (row < nside)
                return;
            re  = 0;
            im  = 0;
            mag = 0;
            if (ok && count != 0)
            begin
                den = longint'(count) << 16;
                re  = sat(rnd_div((n + 1) * rsum, den));
                im  = rnd_div((n + 1) * isum, den);
                if (m < 0)
                    im = -im;
                im  = sat(im);
                mag = root(longint'(re * re + im * im));
                if (mag > 1048575)
                    mag = 1048575;
            end
            res.re  = re[20:0];
            res.im  = im[20:0];
            res.mag = mag[19:0];
            res.ok  = ok;
            pending.push_back(res);
            clear_window();
        endfunction

        function void check_moment(logic signed [20:0] re, logic signed [20:0] im,
                                   logic [19:0] mag, logic ok);
            moment_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected moment re=%0d im=%0d mag=%0d ok=%0b",
                         $time, re, im, mag, ok);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (re !== e.re)
            begin
                $display("%0t: moment_real expected %0d got %0d", $time, e.re, re);
                errors++;
            end
            if (im !== e.im)
            begin
                $display("%0t: moment_imag expected %0d got %0d", $time, e.im, im);
                errors++;
            end
            if (mag !== e.mag)
            begin
                $display("%0t: magnitude expected %0d got %0d", $time, e.mag, mag);
                errors++;
            end
            if (ok !== e.ok)
            begin
                $display("%0t: config_ok expected %0b got %0b", $time, e.ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         pixel;
    logic               out_valid;
    logic               out_stall;
    logic signed [20:0] moment_real;
    logic signed [20:0] moment_imag;
    logic [19:0]        magnitude;
    logic               config_ok;

    moment_predictor    sb;
    longint             cycles;
    int                 tx_pct;
    int                 rx_pct;
    int                 pixels_sent;
    bit                 pressure_done;

    zernike_window_moment uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .moment_real (moment_real),
        .moment_imag (moment_imag),
        .magnitude   (magnitude),
        .config_ok   (config_ok)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("zernike_window_moment regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_moment(moment_real, moment_imag, magnitude, config_ok);
    end

    task automatic send_pixel(bit [7:0] p);
        while ($urandom_range(99) < tx_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    // Let the block drain: all results in, then enough cycles for a partial window.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, bit [6:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic bit [7:0] pick_pixel(int style);
        case (style)
            1: return 8'hFF;
            2: return 8'h00;
            default:
            begin
                case ($urandom_range(9))
                    0: return 8'h00;
                    1: return 8'hFF;
                    default: return 8'($urandom_range(255));
                endcase
            end
        endcase
    endfunction

    task automatic run_phase(bit [3:0] ord, bit [4:0] rp, bit [6:0] sz, int npix, int style);
        int wsize;
        settle();
        write_reg(REG_ORDER, {3'b000, ord});
        write_reg(REG_REPETITION, {2'b00, rp});
        write_reg(REG_WINDOW_SIZE, sz);
        if ($urandom_range(7) == 0)
            write_reg(REG_SPARE, 7'($urandom_range(127)));
        wsize = (sz < 2) ? 4 : (sz > MAX_WINDOW) ? MAX_WINDOW * MAX_WINDOW : sz * sz;
        for (int i = 0; i < npix; i++)
        begin
            send_pixel(pick_pixel(style));
            // hold off once until the first window's result is out
            if (!pressure_done && npix > wsize && i == wsize - 1)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(negedge clk);
                pressure_done = 1'b1;
            end
        end
    endtask

    initial
    begin
        int n;
        int mm;
        int sz;
        int wins;
        int npix;
        bit [4:0] rp;
        sb            = new();
        cycles        = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ORDER;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        pixel         = '0;
        out_stall     = 1'b0;
        tx_pct        = 22;
        rx_pct        = 86;
        pixels_sent   = 0;
        pressure_done = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, odd center, conjugate, invalid pairs, size saturation
        run_phase(4'd0, 5'd0, 7'd2, 4, 1);
        run_phase(4'd12, 5'd12, 7'd3, 9, 0);
        run_phase(4'd12, 5'b10100, 7'd3, 9, 0);
        run_phase(4'd3, 5'd2, 7'd2, 4, 0);
        run_phase(4'd15, 5'b10000, 7'd0, 4, 2);
        run_phase(4'd2, 5'd0, 7'd127, 3, 0);

        while (pixels_sent < ITEM_TARGET)
        begin
            if (pixels_sent < ITEM_TARGET / 3)
            begin
                tx_pct = 22;
                rx_pct = 86;
            end
            else if (pixels_sent < 2 * ITEM_TARGET / 3)
            begin
                tx_pct = 86;
                rx_pct = 22;
            end
            else
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            if ($urandom_range(9) < 7)
            begin
                n  = $urandom_range(MAX_ORDER);
                mm = n - 2 * $urandom_range(n / 2);
                rp = $urandom_range(1) ? 5'(-mm) : 5'(mm);
            end
            else
            begin
                n  = $urandom_range(15);
                rp = 5'($urandom_range(31));
            end
            case ($urandom_range(19))
                0: sz = $urandom_range(127);
                1, 2: sz = $urandom_range(10, 7);
                default: sz = $urandom_range(6, 2);
            endcase
            if (sz > 12 || sz < 2)
                npix = $urandom_range(20, 1);
            else
            begin
                wins = $urandom_range(3, 1);
                npix = wins * sz * sz;
                if ($urandom_range(4) == 0)
                    npix = npix + $urandom_range(sz * sz - 1, 1);
            end
            run_phase(4'(n), rp, 7'(sz), npix, 0);
        end

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("zernike_window_moment regression: pass");
        else
            $display("zernike_window_moment regression: fail");
        $finish;
    end

endmodule
